@@ rtl/core/tpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsd_pkg
// Types, widths and helpers shared by the two-axis PID servo drive.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    localparam int POS_W    = 10;
    localparam int CTR_W    = 8;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int SCL_W    = 12;
    localparam int ST_W     = 32;
    localparam int MA_W     = 44;
    localparam int MB_W     = 17;
    localparam int PROD_W   = 61;
    localparam int VAL_W    = 42;

    localparam logic [MB_W-1:0] DERIV_RATE = 17'd500;
    localparam logic signed [ST_W-1:0] INTEG_LIM = 32'sd5242880;
    localparam logic [CTR_W-1:0] DRIVE_MAX   = 8'd170;
    localparam logic [CTR_W-1:0] DRIVE_MIN_X = 8'd20;
    localparam logic [CTR_W-1:0] DRIVE_MIN_Y = 8'd15;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_X  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_X  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_Y  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_Y  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_Y  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IN_SCALE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE = 4'd7;

    typedef enum logic [3:0] {
        LANE_IDLE, LANE_SP, LANE_ST, LANE_ERR, LANE_RAW, LANE_FILT, LANE_FUPD,
        LANE_PMUL, LANE_IMUL, LANE_DMUL, LANE_SUM, LANE_HMUL, LANE_DONE
    } lane_state_t;

    typedef enum logic [1:0] {
        CTL_IDLE, CTL_RUN, CTL_MERGE
    } ctl_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [GAIN_W-1:0] in_scale;
        logic [GAIN_W-1:0] out_scale;
    } lane_cfg_t;

    typedef struct packed {
        logic                     busy;
        logic signed [VAL_W-1:0]  value;
        logic signed [PROD_W-1:0] held;
    } lane_stat_t;

    function automatic logic [CTR_W-1:0] drive_calc(
        input logic signed [PROD_W-1:0] held,
        input logic signed [VAL_W-1:0]  value,
        input logic [CTR_W-1:0]         center,
        input logic [CTR_W-1:0]         lo
    );
        logic signed [PROD_W-1:0] lim;
        logic signed [VAL_W-1:0]  adj;
        logic signed [VAL_W-1:0]  drv;
        logic [CTR_W-1:0]         res;
        lim = -($signed({{(PROD_W-CTR_W-30){1'b0}}, center, 30'b0}));
        adj = value + (value[VAL_W-1] ? VAL_W'(16'hFFFF) : VAL_W'(0));
        drv = (adj >>> 16) + $signed({{(VAL_W-CTR_W){1'b0}}, center});
        if (held <= lim)
            drv = '0;
        if (drv > $signed({{(VAL_W-CTR_W){1'b0}}, DRIVE_MAX}))
            res = DRIVE_MAX;
        else if (drv < $signed({{(VAL_W-CTR_W){1'b0}}, lo}))
            res = lo;
        else
            res = drv[CTR_W-1:0];
        return res;
    endfunction

endpackage

@@ rtl/core/tpsd_if.sv @@
// ----------------------------------------------------------------------------
// tpsd interfaces
// Request, response and configuration channels of the servo drive.
// ----------------------------------------------------------------------------
interface tpsd_req_if;
    logic                           valid;
    logic                           ready;
    logic [tpsd_pkg::POS_W-1:0]     pos_x;
    logic [tpsd_pkg::POS_W-1:0]     pos_y;
    logic [tpsd_pkg::POS_W-1:0]     target_x;
    logic [tpsd_pkg::POS_W-1:0]     target_y;
    logic [tpsd_pkg::CTR_W-1:0]     center_x;
    logic [tpsd_pkg::CTR_W-1:0]     center_y;
    modport source (output valid, pos_x, pos_y, target_x, target_y, center_x, center_y,
                    input ready);
    modport sink (input valid, pos_x, pos_y, target_x, target_y, center_x, center_y,
                  output ready);
endinterface

interface tpsd_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tpsd_pkg::CTR_W-1:0] drive_x;
    logic [tpsd_pkg::CTR_W-1:0] drive_y;
    logic                       out_of_range;
    modport source (output valid, drive_x, drive_y, out_of_range, input ready);
    modport sink (input valid, drive_x, drive_y, out_of_range, output ready);
endinterface

interface tpsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tpsd_pkg::CFG_IDX_W-1:0] index;
    logic [tpsd_pkg::GAIN_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/tpsd_lane.sv @@
// ----------------------------------------------------------------------------
// tpsd_lane
// One axis PID: input scaling, filtered derivative, clamped integral and
// scaled output, stepped through a single shared multiplier.
// ----------------------------------------------------------------------------
module tpsd_lane #(
    parameter int SMOOTHING = 32768
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpsd_pkg::POS_W-1:0]  pos,
    input  logic [tpsd_pkg::POS_W-1:0]  target,
    input  tpsd_pkg::lane_cfg_t         cfg,
    output tpsd_pkg::lane_stat_t        stat
);

    localparam int MA_W   = tpsd_pkg::MA_W;
    localparam int MB_W   = tpsd_pkg::MB_W;
    localparam int PROD_W = tpsd_pkg::PROD_W;
    localparam int VAL_W  = tpsd_pkg::VAL_W;
    localparam int ST_W   = tpsd_pkg::ST_W;
    localparam int SCL_W  = tpsd_pkg::SCL_W;

    tpsd_pkg::lane_state_t state_reg, state_next;

    logic [tpsd_pkg::POS_W-1:0] pos_reg, tgt_reg;
    logic [SCL_W-1:0]           sp_reg;
    logic signed [ST_W-1:0]     eq_reg, last_reg, filt_reg, integ_reg;
    logic signed [VAL_W-1:0]    p_reg, value_reg;
    logic signed [PROD_W-1:0]   prod_reg, held_reg;
    logic signed [MA_W-1:0]     op_a;
    logic signed [MB_W-1:0]     op_b;
    logic signed [PROD_W-1:0]   prod_next;

    logic [SCL_W-1:0]           st;
    logic signed [SCL_W:0]      err;
    logic signed [PROD_W-1:0]   fsum;
    logic signed [ST_W-1:0]     f_next;
    logic signed [VAL_W-1:0]    isum, dterm;
    logic signed [ST_W-1:0]     i_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpsd_pkg::LANE_IDLE: if (start) state_next = tpsd_pkg::LANE_SP;
            tpsd_pkg::LANE_SP:   state_next = tpsd_pkg::LANE_ST;
            tpsd_pkg::LANE_ST:   state_next = tpsd_pkg::LANE_ERR;
            tpsd_pkg::LANE_ERR:  state_next = tpsd_pkg::LANE_RAW;
            tpsd_pkg::LANE_RAW:  state_next = tpsd_pkg::LANE_FILT;
            tpsd_pkg::LANE_FILT: state_next = tpsd_pkg::LANE_FUPD;
            tpsd_pkg::LANE_FUPD: state_next = tpsd_pkg::LANE_PMUL;
            tpsd_pkg::LANE_PMUL: state_next = tpsd_pkg::LANE_IMUL;
            tpsd_pkg::LANE_IMUL: state_next = tpsd_pkg::LANE_DMUL;
            tpsd_pkg::LANE_DMUL: state_next = tpsd_pkg::LANE_SUM;
            tpsd_pkg::LANE_SUM:  state_next = tpsd_pkg::LANE_HMUL;
            tpsd_pkg::LANE_HMUL: state_next = tpsd_pkg::LANE_DONE;
            tpsd_pkg::LANE_DONE: state_next = tpsd_pkg::LANE_IDLE;
            default:             state_next = tpsd_pkg::LANE_IDLE;
        endcase
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            tpsd_pkg::LANE_SP:
            begin
                op_a = MA_W'(pos_reg);
                op_b = {1'b0, cfg.in_scale};
            end
            tpsd_pkg::LANE_ST:
            begin
                op_a = MA_W'(tgt_reg);
                op_b = {1'b0, cfg.in_scale};
            end
            tpsd_pkg::LANE_RAW:
            begin
                op_a = MA_W'(eq_reg) - MA_W'(last_reg);
                op_b = tpsd_pkg::DERIV_RATE;
            end
            tpsd_pkg::LANE_FILT:
            begin
                op_a = prod_reg[MA_W-1:0] - MA_W'(filt_reg);
                op_b = MB_W'(SMOOTHING);
            end
            tpsd_pkg::LANE_PMUL:
            begin
                op_a = MA_W'(eq_reg);
                op_b = {1'b0, cfg.gain_p};
            end
            tpsd_pkg::LANE_IMUL:
            begin
                op_a = MA_W'(eq_reg);
                op_b = {1'b0, cfg.gain_i};
            end
            tpsd_pkg::LANE_DMUL:
            begin
                op_a = MA_W'(filt_reg);
                op_b = {1'b0, cfg.gain_d};
            end
            tpsd_pkg::LANE_HMUL:
            begin
                op_a = MA_W'(value_reg);
                op_b = {1'b0, cfg.out_scale};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    assign st  = prod_reg[SCL_W+13:14];
    assign err = $signed({1'b0, st}) - $signed({1'b0, sp_reg});

    assign fsum = PROD_W'(filt_reg) + (prod_reg >>> 16);
    always_comb
    begin
        if (fsum > PROD_W'(32'sh7FFF_FFFF))
            f_next = 32'sh7FFF_FFFF;
        else if (fsum < -PROD_W'(33'sh0_8000_0000))
            f_next = 32'sh8000_0000;
        else
            f_next = fsum[ST_W-1:0];
    end

    assign dterm = VAL_W'(prod_reg >>> 8);
    assign isum  = VAL_W'(integ_reg) + dterm;
    always_comb
    begin
        if (isum > VAL_W'(tpsd_pkg::INTEG_LIM))
            i_next = tpsd_pkg::INTEG_LIM;
        else if (isum < -VAL_W'(tpsd_pkg::INTEG_LIM))
            i_next = -tpsd_pkg::INTEG_LIM;
        else
            i_next = isum[ST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpsd_pkg::LANE_IDLE;
            last_reg  <= '0;
            filt_reg  <= '0;
            integ_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                tpsd_pkg::LANE_FUPD: filt_reg  <= f_next;
                tpsd_pkg::LANE_RAW:  last_reg  <= eq_reg;
                tpsd_pkg::LANE_DMUL: integ_reg <= i_next;
                tpsd_pkg::LANE_DONE: held_reg  <= prod_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (state_reg == tpsd_pkg::LANE_IDLE && start)
        begin
            pos_reg <= pos;
            tgt_reg <= target;
        end
        if (state_reg == tpsd_pkg::LANE_ST)
            sp_reg <= prod_reg[SCL_W+13:14];
        if (state_reg == tpsd_pkg::LANE_ERR)
            eq_reg <= ST_W'($signed({err, 16'b0}));
        if (state_reg == tpsd_pkg::LANE_IMUL)
            p_reg <= dterm;
        if (state_reg == tpsd_pkg::LANE_SUM)
            value_reg <= p_reg + VAL_W'(integ_reg) + dterm;
    end

    assign stat.busy  = (state_reg != tpsd_pkg::LANE_IDLE);
    assign stat.value = value_reg;
    assign stat.held  = held_reg;

endmodule

@@ rtl/core/tpsd_merge.sv @@
// ----------------------------------------------------------------------------
// tpsd_merge
// Combine both lanes into servo drives and hold them in the response register.
// ----------------------------------------------------------------------------
module tpsd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        oor,
    input  logic [tpsd_pkg::CTR_W-1:0]  center_x,
    input  logic [tpsd_pkg::CTR_W-1:0]  center_y,
    input  tpsd_pkg::lane_stat_t        lane_x,
    input  tpsd_pkg::lane_stat_t        lane_y,
    output logic                        free,
    tpsd_rsp_if.source                  rsp
);

    logic                       valid_reg;
    logic [tpsd_pkg::CTR_W-1:0] dx_reg, dy_reg;
    logic                       oor_reg;
    logic signed [tpsd_pkg::VAL_W-1:0] vx, vy;

    assign vx = oor ? '0 : lane_x.value;
    assign vy = oor ? '0 : lane_y.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (rsp.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx_reg  <= tpsd_pkg::drive_calc(lane_x.held, vx, center_x, tpsd_pkg::DRIVE_MIN_X);
            dy_reg  <= tpsd_pkg::drive_calc(lane_y.held, vy, center_y, tpsd_pkg::DRIVE_MIN_Y);
            oor_reg <= oor;
        end
    end

    assign free             = !valid_reg || rsp.ready;
    assign rsp.valid        = valid_reg;
    assign rsp.drive_x      = dx_reg;
    assign rsp.drive_y      = dy_reg;
    assign rsp.out_of_range = oor_reg;

endmodule

@@ rtl/core/two_axis_pid_servo_drive.sv @@
// ----------------------------------------------------------------------------
// two_axis_pid_servo_drive
// One item at a time: an in-frame item runs through the 12-step lane sequencer,
// an out-of-frame item goes straight to the merge.
// A new request is taken while a finished response waits.
// Reset clears gains to zero, both scales to 1.0 and all PID state to zero.
// ----------------------------------------------------------------------------
module two_axis_pid_servo_drive #(
    parameter int WIDTH     = 640,
    parameter int HEIGHT    = 480,
    parameter int SMOOTHING = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    tpsd_cfg_if.sink    cfg,
    tpsd_req_if.sink    req,
    tpsd_rsp_if.source  rsp
);

    localparam int GW = tpsd_pkg::GAIN_W;

    tpsd_pkg::ctl_state_t state_reg, state_next;

    logic [GW-1:0] gp_x_reg, gi_x_reg, gd_x_reg, gp_y_reg, gi_y_reg, gd_y_reg;
    logic [GW-1:0] in_scale_reg, out_scale_reg;
    logic [tpsd_pkg::CTR_W-1:0] cx_reg, cy_reg;
    logic oor_reg, oor_in, accept, start, load, free;
    tpsd_pkg::lane_cfg_t  cfg_x, cfg_y;
    tpsd_pkg::lane_stat_t stat_x, stat_y;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_x_reg      <= '0;
            gi_x_reg      <= '0;
            gd_x_reg      <= '0;
            gp_y_reg      <= '0;
            gi_y_reg      <= '0;
            gd_y_reg      <= '0;
            in_scale_reg  <= GW'(16384);
            out_scale_reg <= GW'(16384);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tpsd_pkg::REG_GAIN_P_X:  gp_x_reg      <= cfg.data;
                tpsd_pkg::REG_GAIN_I_X:  gi_x_reg      <= cfg.data;
                tpsd_pkg::REG_GAIN_D_X:  gd_x_reg      <= cfg.data;
                tpsd_pkg::REG_GAIN_P_Y:  gp_y_reg      <= cfg.data;
                tpsd_pkg::REG_GAIN_I_Y:  gi_y_reg      <= cfg.data;
                tpsd_pkg::REG_GAIN_D_Y:  gd_y_reg      <= cfg.data;
                tpsd_pkg::REG_IN_SCALE:  in_scale_reg  <= cfg.data;
                tpsd_pkg::REG_OUT_SCALE: out_scale_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign oor_in = (req.pos_x > tpsd_pkg::POS_W'(WIDTH)) ||
                    (req.pos_y > tpsd_pkg::POS_W'(HEIGHT));
    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpsd_pkg::CTL_IDLE:
                if (accept)
                    state_next = oor_in ? tpsd_pkg::CTL_MERGE : tpsd_pkg::CTL_RUN;
            tpsd_pkg::CTL_RUN:
                if (!stat_x.busy && !stat_y.busy)
                    state_next = tpsd_pkg::CTL_MERGE;
            tpsd_pkg::CTL_MERGE:
                if (free)
                    state_next = tpsd_pkg::CTL_IDLE;
            default: state_next = tpsd_pkg::CTL_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == tpsd_pkg::CTL_IDLE);
        start     = (state_reg == tpsd_pkg::CTL_IDLE) && req.valid && !oor_in;
        load      = (state_reg == tpsd_pkg::CTL_MERGE) && free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tpsd_pkg::CTL_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg  <= req.center_x;
            cy_reg  <= req.center_y;
            oor_reg <= oor_in;
        end
    end

    assign cfg_x = '{gain_p: gp_x_reg, gain_i: gi_x_reg, gain_d: gd_x_reg,
                     in_scale: in_scale_reg, out_scale: out_scale_reg};
    assign cfg_y = '{gain_p: gp_y_reg, gain_i: gi_y_reg, gain_d: gd_y_reg,
                     in_scale: in_scale_reg, out_scale: out_scale_reg};

    tpsd_lane #(.SMOOTHING(SMOOTHING)) u_lane_x (
        .clk(clk), .rst_n(rst_n), .start(start),
        .pos(req.pos_x), .target(req.target_x), .cfg(cfg_x), .stat(stat_x)
    );

    tpsd_lane #(.SMOOTHING(SMOOTHING)) u_lane_y (
        .clk(clk), .rst_n(rst_n), .start(start),
        .pos(req.pos_y), .target(req.target_y), .cfg(cfg_y), .stat(stat_y)
    );

    tpsd_merge u_merge (
        .clk(clk), .rst_n(rst_n), .load(load), .oor(oor_reg),
        .center_x(cx_reg), .center_y(cy_reg),
        .lane_x(stat_x), .lane_y(stat_y), .free(free), .rsp(rsp)
    );

endmodule

@@ test/tpsd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsd_checker
// Watches the configuration, request and response channels of the servo
// drive, predicts each drive pair from its own copy of the PID state and
// compares every response against the oldest predicted drive pair.
// ----------------------------------------------------------------------------
module tpsd_checker #(
    parameter int WIDTH     = 640,
    parameter int HEIGHT    = 480,
    parameter int SMOOTHING = 32768
) (
    input  logic clk,
    input  logic rst_n,
    tpsd_cfg_if  cfg,
    tpsd_req_if  req,
    tpsd_rsp_if  rsp,
    output int   mismatch_count,
    output int   drives_pending
);

    typedef struct packed {
        logic [tpsd_pkg::CTR_W-1:0] drive_x;
        logic [tpsd_pkg::CTR_W-1:0] drive_y;
        logic                       out_of_range;
    } drive_pair_t;

    logic [tpsd_pkg::GAIN_W-1:0]      kp [2];
    logic [tpsd_pkg::GAIN_W-1:0]      ki [2];
    logic [tpsd_pkg::GAIN_W-1:0]      kd [2];
    logic [tpsd_pkg::GAIN_W-1:0]      in_scale;
    logic [tpsd_pkg::GAIN_W-1:0]      out_scale;
    logic signed [tpsd_pkg::ST_W-1:0] prev_err [2];
    logic signed [tpsd_pkg::ST_W-1:0] deriv_f [2];
    logic signed [tpsd_pkg::ST_W-1:0] integ [2];
    logic signed [63:0]               held [2];
    drive_pair_t                      drive_fifo [$];

    assign drives_pending = drive_fifo.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [63:0] scale_pos(input logic [tpsd_pkg::POS_W-1:0] p);
        logic [63:0] prod;
        prod = 64'(p) * 64'(in_scale);
        return $signed(prod >> 14);
    endfunction

    task automatic pid_axis(input int a, input logic signed [63:0] err,
                            output logic signed [63:0] value);
        logic signed [63:0] eq, raw, f, p, in, d, lim;
        eq  = err * 64'sd65536;
        raw = (eq - 64'(prev_err[a])) * 64'sd500;
        f   = 64'(deriv_f[a]);
        f   = f + (((raw - f) * 64'(SMOOTHING)) >>> 16);
        if (f > 64'sd2147483647)
            f = 64'sd2147483647;
        else if (f < -64'sd2147483648)
            f = -64'sd2147483648;
        deriv_f[a]  = f[31:0];
        prev_err[a] = eq[31:0];
        lim = 64'sd80 * 64'sd65536;
        p   = ($signed({48'b0, kp[a]}) * eq) >>> 8;
        in  = 64'(integ[a]) + (($signed({48'b0, ki[a]}) * eq) >>> 8);
        if (in > lim)
            in = lim;
        else if (in < -lim)
            in = -lim;
        integ[a] = in[31:0];
        d = ($signed({48'b0, kd[a]}) * f) >>> 8;
        value = p + in + d;
    endtask

    function automatic logic [tpsd_pkg::CTR_W-1:0] servo_drive(
        input logic signed [63:0]         hs,
        input logic signed [63:0]         value,
        input logic [tpsd_pkg::CTR_W-1:0] center,
        input logic [tpsd_pkg::CTR_W-1:0] lo
    );
        logic signed [63:0] c, drv, hi_s, lo_s;
        c    = 64'(center);
        hi_s = 64'(tpsd_pkg::DRIVE_MAX);
        lo_s = 64'(lo);
        if (hs <= -(c <<< 30))
            drv = 0;
        else if (value < 0)
            drv = c - ((-value) >>> 16);
        else
            drv = c + (value >>> 16);
        if (drv > hi_s)
            drv = hi_s;
        else if (drv < lo_s)
            drv = lo_s;
        return drv[tpsd_pkg::CTR_W-1:0];
    endfunction

    task automatic predict_drive();
        logic signed [63:0] vx, vy;
        drive_pair_t e;
        vx = 0;
        vy = 0;
        e.out_of_range = (req.pos_x > WIDTH) || (req.pos_y > HEIGHT);
        if (!e.out_of_range)
        begin
            pid_axis(0, scale_pos(req.target_x) - scale_pos(req.pos_x), vx);
            pid_axis(1, scale_pos(req.target_y) - scale_pos(req.pos_y), vy);
            held[0] = vx * 64'(out_scale);
            held[1] = vy * 64'(out_scale);
        end
        e.drive_x = servo_drive(held[0], vx, req.center_x, tpsd_pkg::DRIVE_MIN_X);
        e.drive_y = servo_drive(held[1], vy, req.center_y, tpsd_pkg::DRIVE_MIN_Y);
        drive_fifo.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                kp[a] = '0;
                ki[a] = '0;
                kd[a] = '0;
                prev_err[a] = '0;
                deriv_f[a] = '0;
                integ[a] = '0;
                held[a] = '0;
            end
            in_scale = 16'd16384;
            out_scale = 16'd16384;
            mismatch_count = 0;
            drive_fifo.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tpsd_pkg::REG_GAIN_P_X:  kp[0] = cfg.data;
                    tpsd_pkg::REG_GAIN_I_X:  ki[0] = cfg.data;
                    tpsd_pkg::REG_GAIN_D_X:  kd[0] = cfg.data;
                    tpsd_pkg::REG_GAIN_P_Y:  kp[1] = cfg.data;
                    tpsd_pkg::REG_GAIN_I_Y:  ki[1] = cfg.data;
                    tpsd_pkg::REG_GAIN_D_Y:  kd[1] = cfg.data;
                    tpsd_pkg::REG_IN_SCALE:  in_scale = cfg.data;
                    tpsd_pkg::REG_OUT_SCALE: out_scale = cfg.data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (drive_fifo.size() == 0)
                    report_mismatch("unexpected response", 1, 0);
                else
                begin
                    drive_pair_t e;
                    e = drive_fifo.pop_front();
                    if (rsp.drive_x !== e.drive_x)
                        report_mismatch("drive_x", rsp.drive_x, e.drive_x);
                    if (rsp.drive_y !== e.drive_y)
                        report_mismatch("drive_y", rsp.drive_y, e.drive_y);
                    if (rsp.out_of_range !== e.out_of_range)
                        report_mismatch("out_of_range", rsp.out_of_range, e.out_of_range);
                end
            end
            if (req.valid && req.ready)
                predict_drive();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the servo drive through several gain and scale settings with
// directed corner items and random camera frames, with random idle bursts on
// both channels, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatch_count;
    int   drives_pending;

    tpsd_cfg_if cfg_ch ();
    tpsd_req_if req_ch ();
    tpsd_rsp_if rsp_ch ();

    two_axis_pid_servo_drive u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    tpsd_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .drives_pending (drives_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
                stall--;
            else if (!calm && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 5);
            rsp_ch.ready <= (stall == 0);
        end
    end

    task automatic write_reg(input logic [tpsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpsd_pkg::GAIN_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (drives_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_frame(input int px, input int py, input int tx, input int ty,
                              input int cx, input int cy);
        int gap;
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.pos_x    <= tpsd_pkg::POS_W'(px);
        req_ch.pos_y    <= tpsd_pkg::POS_W'(py);
        req_ch.target_x <= tpsd_pkg::POS_W'(tx);
        req_ch.target_y <= tpsd_pkg::POS_W'(ty);
        req_ch.center_x <= tpsd_pkg::CTR_W'(cx);
        req_ch.center_y <= tpsd_pkg::CTR_W'(cy);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random();
        if ($urandom_range(0, 9) == 0)
            send_frame($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        else
            send_frame($urandom_range(0, 640), $urandom_range(0, 480),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(60, 120), $urandom_range(60, 120));
    endtask

    function automatic logic [tpsd_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hFFFF;
            2: return tpsd_pkg::GAIN_W'($urandom_range(0, 65535));
            default: return tpsd_pkg::GAIN_W'($urandom_range(0, 600));
        endcase
    endfunction

    initial
    begin
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.pos_x = '0;
        req_ch.pos_y = '0;
        req_ch.target_x = '0;
        req_ch.target_y = '0;
        req_ch.center_x = '0;
        req_ch.center_y = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        send_frame(0, 0, 0, 0, 0, 0);
        send_frame(320, 240, 1023, 1023, 255, 255);
        send_frame(640, 480, 0, 0, 100, 100);
        send_frame(641, 100, 10, 10, 90, 90);
        send_frame(100, 481, 10, 10, 90, 90);
        send_frame(1023, 1023, 1023, 1023, 255, 0);
        drain();

        write_reg(tpsd_pkg::REG_GAIN_P_X, 16'd256);
        write_reg(tpsd_pkg::REG_GAIN_I_X, 16'd64);
        write_reg(tpsd_pkg::REG_GAIN_D_X, 16'd1);
        write_reg(tpsd_pkg::REG_GAIN_P_Y, 16'd256);
        write_reg(tpsd_pkg::REG_GAIN_I_Y, 16'd64);
        write_reg(tpsd_pkg::REG_GAIN_D_Y, 16'd1);
        write_reg(4'd8, 16'hFFFF);
        write_reg(4'd15, 16'h1234);
        send_frame(101, 100, 100, 100, 1, 1);
        send_frame(101, 100, 100, 100, 2, 2);
        send_frame(100, 100, 101, 101, 0, 0);
        send_frame(640, 480, 0, 0, 255, 255);
        send_frame(0, 0, 640, 480, 100, 100);
        send_frame(700, 0, 0, 0, 100, 100);
        send_frame(0, 0, 640, 480, 100, 100);
        drain();

        write_reg(tpsd_pkg::REG_OUT_SCALE, 16'd0);
        write_reg(tpsd_pkg::REG_IN_SCALE, 16'hFFFF);
        write_reg(tpsd_pkg::REG_GAIN_P_X, 16'hFFFF);
        write_reg(tpsd_pkg::REG_GAIN_I_X, 16'hFFFF);
        write_reg(tpsd_pkg::REG_GAIN_D_X, 16'hFFFF);
        write_reg(tpsd_pkg::REG_GAIN_D_Y, 16'hFFFF);
        send_frame(0, 0, 1023, 1023, 0, 0);
        send_frame(640, 480, 0, 0, 0, 255);
        send_frame(0, 480, 1023, 0, 128, 128);
        send_frame(640, 0, 0, 1023, 128, 128);
        drain();
        write_reg(tpsd_pkg::REG_IN_SCALE, 16'd0);
        write_reg(tpsd_pkg::REG_OUT_SCALE, 16'hFFFF);
        send_frame(300, 200, 900, 10, 100, 100);
        send_frame(300, 200, 900, 10, 0, 0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(tpsd_pkg::REG_GAIN_P_X, pick_gain());
            write_reg(tpsd_pkg::REG_GAIN_I_X, pick_gain());
            write_reg(tpsd_pkg::REG_GAIN_D_X, pick_gain());
            write_reg(tpsd_pkg::REG_GAIN_P_Y, pick_gain());
            write_reg(tpsd_pkg::REG_GAIN_I_Y, pick_gain());
            write_reg(tpsd_pkg::REG_GAIN_D_Y, pick_gain());
            write_reg(tpsd_pkg::REG_IN_SCALE, (phase == 1) ? 16'hFFFF :
                      tpsd_pkg::GAIN_W'($urandom_range(4096, 32768)));
            write_reg(tpsd_pkg::REG_OUT_SCALE, (phase == 2) ? 16'd0 :
                      tpsd_pkg::GAIN_W'($urandom_range(0, 65535)));
            if (phase == 5)
                calm = 1'b1;
            for (int n = 0; n < 300; n++)
            begin
                send_random();
                if (phase == 3 && n == 150)
                    drain();
            end
            @(negedge clk);
            req_ch.valid <= 1'b0;
            drain();
        end

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
